[sv/rmt_pkg.sv]
// package for the running mean table: widths, function codes, fsm states
// no dependencies
`default_nettype none
package rmt_pkg;
   localparam int MAX_ENTRIES_DEF = 4096;
   localparam int DATA_W = 32;
   localparam int ID_W = 12;
   localparam int RARE_W = 13;

   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0, FUNC_EMPTY = 3'd1, FUNC_PICK = 3'd2,
      FUNC_READ = 3'd3, FUNC_CLEAR = 3'd4
   } func_type;

   localparam logic [0:0] CSR_TARGET = 1'b0;
   localparam logic [0:0] CSR_INUSE = 1'b1;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_READ, ST_DIVIDE, ST_WRITE, ST_SWAP1, ST_SWAP2,
      ST_PICK, ST_REPORT, ST_CLEAR, ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [32:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

[sv/rmt_if.sv]
// request and response channel interfaces for the running mean table
// payload widths come from rmt_pkg
`default_nettype none
interface rmt_req_if import rmt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [2:0]               func;
   logic [ID_W-1:0]          entry_id;
   logic signed [DATA_W-1:0] sample_value;
   logic [DATA_W-1:0]        random_word;
   modport source(output valid, func, entry_id, sample_value, random_word, input ready);
   modport sink(input valid, func, entry_id, sample_value, random_word, output ready);
endinterface

interface rmt_rsp_if import rmt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic [ID_W-1:0]          chosen_entry;
   logic [DATA_W-1:0]        entry_count;
   logic signed [DATA_W-1:0] entry_mean;
   logic [ID_W-1:0]          entry_position;
   logic signed [DATA_W-1:0] relative_value;
   logic [RARE_W-1:0]        rare_count;
   modport source(output valid, ok, chosen_entry, entry_count, entry_mean, entry_position,
                  relative_value, rare_count, input ready);
   modport sink(input valid, ok, chosen_entry, entry_count, entry_mean, entry_position,
                relative_value, rare_count, output ready);
endinterface
`default_nettype wire

[sv/rmt_ram.sv]
// generic single port ram with registered read
// no dependencies
`default_nettype none
module rmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

[sv/rmt_div.sv]
// restoring divider, signed 33-bit dividend by unsigned 32-bit divisor, truncating
// uses rmt_pkg request and response structs
`default_nettype none
module rmt_div import rmt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [32:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff, quo_ff[32]} - {2'b0, dvs_ff};
      rsp.done = 1'b0;
      rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      if (req.start) begin
         neg_in = req.dividend[32];
         quo_in = req.dividend[32] ? -req.dividend : req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            rsp.done = 1'b1;
         end else begin
            if (!trial[33]) begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], quo_ff[32]};
               quo_in = {quo_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

[sv/running_mean_table_with_rare_partition_core.sv]
// running mean table with rare partition: top level
// request paths: add reads, divides, writes and swaps if needed; empty sample divides only;
// read reads; pick draws a rare entry and reads it, if any; unused codes respond directly
// throughput: one request at a time; ready again the cycle after the response is delivered
// reset: a clearing pass over all entries writes identity permutation and zero stores,
// no request taken meanwhile; clear request sweeps all MAX_ENTRIES entries of count and mean
// depends on rmt_pkg, rmt_if, rmt_ram, rmt_div
`default_nettype none
module running_mean_table_with_rare_partition_core import rmt_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   rmt_req_if.sink                req,
   rmt_rsp_if.source              rsp,
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_index,
   input  wire logic [DATA_W-1:0] csr_wdata
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int NW = AW + 1;

   state_type st_ff, st_in;
   logic [DATA_W-1:0] target_ff;
   logic [RARE_W-1:0] inuse_ff;
   logic [NW-1:0]     rare_ff, rare_in;
   logic [DATA_W-1:0] ecnt_ff, ecnt_in;
   logic [DATA_W-1:0] emean_ff, emean_in;
   logic [NW-1:0]     sweep_ff, sweep_in;
   logic [2:0]        func_ff, func_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [AW-1:0]     ent_ff, ent_in;
   logic [DATA_W-1:0] samp_ff, samp_in, rnd_ff, rnd_in;
   logic [DATA_W-1:0] cnt_ff, cnt_in, mean_ff, mean_in;
   logic [AW-1:0]     pos_ff, pos_in, other_ff, other_in;
   logic              rv_ff, rv_in, ok_ff, ok_in;
   logic [ID_W-1:0]   oce_ff, oce_in, opos_ff, opos_in;
   logic [DATA_W-1:0] ocnt_ff, ocnt_in, omean_ff, omean_in, orel_ff, orel_in;

   logic cwe, mwe, pwe, ewe;
   logic [AW-1:0] caddr, paddr, eaddr;
   logic [DATA_W-1:0] cwd, mwd, crd, mrd;
   logic [AW-1:0] pwd, ewd, prd, erd;
   div_req_type dreq;
   div_rsp_type drsp;

   rmt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_cnt (
      .clock, .we(cwe), .addr(caddr), .wdata(cwd), .rdata(crd));
   rmt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_mean (
      .clock, .we(mwe), .addr(caddr), .wdata(mwd), .rdata(mrd));
   rmt_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_pos (
      .clock, .we(pwe), .addr(paddr), .wdata(pwd), .rdata(prd));
   rmt_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_ent (
      .clock, .we(ewe), .addr(eaddr), .wdata(ewd), .rdata(erd));
   rmt_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   logic [NW-1:0] n_live;
   logic          in_range, emp;
   logic [DATA_W-1:0] ncnt;
   logic [DATA_W-1:0] newmean;
   logic [63:0]   prod;
   logic signed [33:0] rel;

   always_comb begin
      if (inuse_ff == '0) n_live = NW'(1);
      else if (32'(inuse_ff) > 32'(MAX_ENTRIES)) n_live = NW'(MAX_ENTRIES);
      else n_live = NW'(inuse_ff);
   end

   assign in_range = (NW+ID_W)'(id_ff) < (NW+ID_W)'(n_live);
   assign emp = func_ff == FUNC_EMPTY;
   assign prod = rnd_ff * 64'(rare_ff);
   assign newmean = DATA_W'($signed({mean_ff[31], mean_ff}) + drsp.quotient);

   always_comb begin
      st_in = st_ff; rare_in = rare_ff; ecnt_in = ecnt_ff; emean_in = emean_ff;
      sweep_in = sweep_ff; func_in = func_ff; id_in = id_ff; ent_in = ent_ff;
      samp_in = samp_ff; rnd_in = rnd_ff; cnt_in = cnt_ff; mean_in = mean_ff;
      pos_in = pos_ff; other_in = other_ff; rv_in = rv_ff; ok_in = ok_ff;
      oce_in = oce_ff; opos_in = opos_ff; ocnt_in = ocnt_ff; omean_in = omean_ff;
      orel_in = orel_ff;
      cwe = 1'b0; mwe = 1'b0; pwe = 1'b0; ewe = 1'b0;
      caddr = ent_ff; paddr = ent_ff; eaddr = ent_ff;
      cwd = '0; mwd = '0; pwd = '0; ewd = '0;
      dreq.start = 1'b0;
      ncnt = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
      dreq.divisor = ncnt;
      dreq.dividend = 33'($signed({samp_ff[31], samp_ff}) - $signed({mean_ff[31], mean_ff}));
      rel = $signed({{2{omean_ff[31]}}, omean_ff}) - $signed({{2{emean_ff[31]}}, emean_ff});
      req.ready = 1'b0;
      unique case (st_ff)
         ST_INIT: begin
            caddr = sweep_ff[AW-1:0]; paddr = sweep_ff[AW-1:0]; eaddr = sweep_ff[AW-1:0];
            cwe = 1'b1; mwe = 1'b1; pwe = 1'b1; ewe = 1'b1;
            pwd = sweep_ff[AW-1:0]; ewd = sweep_ff[AW-1:0];
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == NW'(MAX_ENTRIES-1)) begin
               st_in = ST_IDLE; rare_in = n_live;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               func_in = req.func; id_in = req.entry_id; ent_in = AW'(req.entry_id);
               samp_in = req.sample_value; rnd_in = req.random_word;
               ok_in = 1'b0; oce_in = '0; opos_in = '0; ocnt_in = '0; omean_in = '0;
               orel_in = '0; rv_in = 1'b0; sweep_in = '0;
               unique case (req.func)
                  FUNC_ADD, FUNC_READ: st_in = ST_READ;
                  FUNC_EMPTY: begin
                     cnt_in = ecnt_ff; mean_in = emean_ff; st_in = ST_DIVIDE;
                  end
                  FUNC_PICK: st_in = ST_PICK;
                  FUNC_CLEAR: st_in = ST_CLEAR;
                  default: st_in = ST_OUT;
               endcase
            end
         end
         ST_READ: begin
            if (!in_range && func_ff != FUNC_PICK) begin
               oce_in = id_ff; st_in = ST_OUT;
            end else if (!rv_ff) begin
               rv_in = 1'b1;
            end else begin
               cnt_in = crd; mean_in = mrd; pos_in = prd;
               if (func_ff == FUNC_ADD) begin
                  st_in = ST_DIVIDE; rv_in = 1'b0;
               end else begin
                  ocnt_in = crd; omean_in = mrd; st_in = ST_REPORT;
               end
            end
         end
         ST_DIVIDE: begin
            if (!rv_ff) begin
               dreq.start = 1'b1; rv_in = 1'b1;
            end else if (drsp.done) begin
               cnt_in = ncnt; mean_in = newmean; rv_in = 1'b0;
               st_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (emp) begin
               ecnt_in = cnt_ff; emean_in = mean_ff;
               ok_in = 1'b1; ocnt_in = cnt_ff; omean_in = mean_ff; st_in = ST_OUT;
            end else begin
               cwe = 1'b1; mwe = 1'b1; cwd = cnt_ff; mwd = mean_ff;
               ocnt_in = cnt_ff; omean_in = mean_ff;
               if (cnt_ff == target_ff && NW'(pos_ff) < rare_ff) begin
                  eaddr = AW'(rare_ff - 1'b1); st_in = ST_SWAP1;
               end else st_in = ST_REPORT;
            end
         end
         ST_SWAP1: begin
            eaddr = AW'(rare_ff - 1'b1);
            if (!rv_ff) rv_in = 1'b1;
            else begin
               other_in = erd; rv_in = 1'b0;
               ewe = 1'b1; ewd = ent_ff;
               pwe = 1'b1; pwd = AW'(rare_ff - 1'b1);
               st_in = ST_SWAP2;
            end
         end
         ST_SWAP2: begin
            eaddr = pos_ff; ewe = 1'b1; ewd = other_ff;
            paddr = other_ff; pwe = 1'b1; pwd = pos_ff;
            pos_in = AW'(rare_ff - 1'b1);
            rare_in = rare_ff - 1'b1;
            st_in = ST_REPORT;
         end
         ST_PICK: begin
            if (rare_ff == '0) st_in = ST_OUT;
            else begin
               eaddr = AW'(prod[63:32]);
               if (!rv_ff) rv_in = 1'b1;
               else begin
                  ent_in = erd; id_in = ID_W'(erd);
                  rv_in = 1'b0; st_in = ST_READ;
               end
            end
         end
         ST_REPORT: begin
            ok_in = 1'b1; oce_in = id_ff; opos_in = ID_W'(pos_ff);
            if (ocnt_ff == '0) orel_in = '0;
            else if (rel > 34'sh7fffffff) orel_in = 32'h7fffffff;
            else if (rel < -34'sh80000000) orel_in = 32'h80000000;
            else orel_in = rel[31:0];
            st_in = ST_OUT;
         end
         ST_CLEAR: begin
            caddr = sweep_ff[AW-1:0]; cwe = 1'b1; mwe = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == NW'(MAX_ENTRIES-1)) begin
               ecnt_in = '0; emean_in = '0; rare_in = n_live; ok_in = 1'b1;
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = st_ff == ST_OUT;
   assign rsp.ok = ok_ff;
   assign rsp.chosen_entry = oce_ff;
   assign rsp.entry_count = ocnt_ff;
   assign rsp.entry_mean = omean_ff;
   assign rsp.entry_position = opos_ff;
   assign rsp.relative_value = orel_ff;
   assign rsp.rare_count = RARE_W'(rare_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_INIT; sweep_ff <= '0; rv_ff <= 1'b0;
         target_ff <= 32'd1; inuse_ff <= RARE_W'(4096);
         rare_ff <= '0; ecnt_ff <= '0; emean_ff <= '0;
      end else begin
         st_ff <= st_in; sweep_ff <= sweep_in; rv_ff <= rv_in;
         rare_ff <= rare_in; ecnt_ff <= ecnt_in; emean_ff <= emean_in;
         if (csr_we && csr_index == CSR_TARGET) target_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_INUSE) inuse_ff <= csr_wdata[RARE_W-1:0];
      end
      func_ff <= func_in; id_ff <= id_in; ent_ff <= ent_in; samp_ff <= samp_in;
      rnd_ff <= rnd_in; cnt_ff <= cnt_in; mean_ff <= mean_in; pos_ff <= pos_in;
      other_ff <= other_in; ok_ff <= ok_in; oce_ff <= oce_in; opos_ff <= opos_in;
      ocnt_ff <= ocnt_in; omean_ff <= omean_in; orel_ff <= orel_in;
   end
endmodule
`default_nettype wire

[sv/rmt_checker.sv]
// port level checks for the running mean table, bound to the top level
// depends on rmt_pkg
`default_nettype none
module rmt_checker import rmt_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_ok,
   input wire logic [DATA_W-1:0] rsp_entry_count,
   input wire logic [RARE_W-1:0] rsp_rare_count
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("response dropped while stalled");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");
   a_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted");
   a_rare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_entry_count == '0)
      else $error("failed response carries a count");
   a_rare_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rare_count <= RARE_W'(MAX_ENTRIES_DEF))
      else $error("rare count beyond table size");
endmodule

bind running_mean_table_with_rare_partition_core rmt_checker u_rmt_checker (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_ok(rsp.ok),
   .rsp_entry_count(rsp.entry_count), .rsp_rare_count(rsp.rare_count));
`default_nettype wire
